// ===== sv/byte_ring_fifo_block_commit_top_defines.svh =====
// Assertion helpers shared by the checking code of the block.
`ifndef BYTE_RING_FIFO_BLOCK_COMMIT_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_BLOCK_COMMIT_TOP_DEFINES_SVH

// Property checked on every clock outside reset.
`define BRFBC_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("brfbc check failed");

// Same-cycle implication.
`define BRFBC_IMPLIES(label, ante, cons) \
  `BRFBC_CHECK(label, (ante) |-> (cons))

`endif

// ===== sv/brfbc_pkg.sv =====
package brfbc_pkg;

  localparam int DEPTH    = 256;
  localparam int MAX_READ = 64;
  localparam int AW       = $clog2(DEPTH);
  localparam int FW       = AW + 1;
  localparam int LEN_W    = 7;
  localparam int CNT_W    = $clog2(MAX_READ + 1);
  localparam int CMP_W    = (FW > LEN_W) ? FW : LEN_W;

  typedef struct packed {
    logic             func;
    logic [7:0]       wr_byte;
    logic             block_end;
    logic [LEN_W-1:0] read_len;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [7:0] rd_byte;
    logic       run_end;
    logic [7:0] fill_count;
  } out_t;

  typedef enum logic [2:0] {
    OP_WR,
    OP_WR_END,
    OP_RD_ZERO,
    OP_RD_BAD,
    OP_RD
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [FW-1:0] ring_fill(input logic [AW-1:0] h,
                                              input logic [AW-1:0] t);
    ring_fill = FW'(h) - FW'(t) + ((h < t) ? FW'(DEPTH) : '0);
  endfunction

endpackage

// ===== sv/brfbc_front.sv =====
module brfbc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  brfbc_pkg::in_t     in_data,
  output logic               q_valid,
  output brfbc_pkg::cmd_t    q_cmd,
  input  logic               q_pop
);

  brfbc_pkg::cmd_t slots [2];
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  brfbc_pkg::cmd_t cmd;
  logic            push;

  always_comb begin
    cmd.data = in_data.wr_byte;
    cmd.len  = in_data.read_len;
    if (in_data.func == 1'b0) begin
      cmd.op = in_data.block_end ? brfbc_pkg::OP_WR_END : brfbc_pkg::OP_WR;
    end else if (in_data.read_len == '0) begin
      cmd.op = brfbc_pkg::OP_RD_ZERO;
    end else if (in_data.read_len > brfbc_pkg::LEN_W'(brfbc_pkg::MAX_READ)) begin
      cmd.op = brfbc_pkg::OP_RD_BAD;
    end else begin
      cmd.op = brfbc_pkg::OP_RD;
    end
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== sv/brfbc_back.sv =====
module brfbc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  brfbc_pkg::cmd_t q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output brfbc_pkg::out_t out_data
);

  logic [7:0]                  mem [brfbc_pkg::DEPTH];
  logic [7:0]                  mem_q;
  logic [brfbc_pkg::AW-1:0]    head, head_next;
  logic [brfbc_pkg::AW-1:0]    tail, tail_next;
  logic [brfbc_pkg::AW-1:0]    ph, ph_next;
  logic                        ovf, ovf_next;
  brfbc_pkg::state_t           state, state_next;
  logic [brfbc_pkg::CNT_W-1:0] cnt, cnt_next;

  logic                        pv;
  logic                        p_status;
  logic                        p_run_end;
  logic                        p_mem;
  logic [7:0]                  p_fill;

  logic                        taken, move, issue_ok, issue;
  logic                        iss_status, iss_run_end, iss_mem;
  logic [brfbc_pkg::FW-1:0]    iss_fill;
  logic                        mem_we;
  logic [brfbc_pkg::AW-1:0]    nph, ntail;
  logic                        fit;
  logic [brfbc_pkg::FW-1:0]    cur_fill;

  assign taken    = out_valid && !out_stall;
  assign move     = pv && (!out_valid || taken);
  assign issue_ok = !pv || move;
  assign nph      = brfbc_pkg::ring_next(ph);
  assign ntail    = brfbc_pkg::ring_next(tail);
  assign fit      = (nph != tail);
  assign cur_fill = brfbc_pkg::ring_fill(head, tail);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    ph_next     = ph;
    ovf_next    = ovf;
    state_next  = state;
    cnt_next    = cnt;
    q_pop       = 1'b0;
    issue       = 1'b0;
    iss_status  = 1'b0;
    iss_run_end = 1'b1;
    iss_mem     = 1'b0;
    iss_fill    = cur_fill;
    mem_we      = 1'b0;
    unique case (state)
      brfbc_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            brfbc_pkg::OP_WR: begin
              q_pop = 1'b1;
              if (!ovf) begin
                if (fit) begin
                  mem_we  = 1'b1;
                  ph_next = nph;
                end else begin
                  ovf_next = 1'b1;
                end
              end
            end
            brfbc_pkg::OP_WR_END: begin
              if (issue_ok) begin
                q_pop    = 1'b1;
                issue    = 1'b1;
                ovf_next = 1'b0;
                if (ovf || !fit) begin
                  iss_status = 1'b1;
                  ph_next    = head;
                end else begin
                  mem_we    = 1'b1;
                  head_next = nph;
                  ph_next   = nph;
                  iss_fill  = brfbc_pkg::ring_fill(nph, tail);
                end
              end
            end
            brfbc_pkg::OP_RD_ZERO: begin
              if (issue_ok) begin
                q_pop = 1'b1;
                issue = 1'b1;
              end
            end
            brfbc_pkg::OP_RD_BAD: begin
              if (issue_ok) begin
                q_pop      = 1'b1;
                issue      = 1'b1;
                iss_status = 1'b1;
              end
            end
            brfbc_pkg::OP_RD: begin
              if (issue_ok) begin
                q_pop = 1'b1;
                if (brfbc_pkg::CMP_W'(cur_fill) < brfbc_pkg::CMP_W'(q_cmd.len)) begin
                  issue      = 1'b1;
                  iss_status = 1'b1;
                end else begin
                  state_next = brfbc_pkg::ST_READ;
                  cnt_next   = brfbc_pkg::CNT_W'(q_cmd.len);
                end
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      brfbc_pkg::ST_READ: begin
        if (issue_ok) begin
          issue       = 1'b1;
          iss_mem     = 1'b1;
          iss_run_end = (cnt == brfbc_pkg::CNT_W'(1));
          iss_fill    = brfbc_pkg::ring_fill(head, ntail);
          tail_next   = ntail;
          cnt_next    = cnt - 1'b1;
          if (cnt == brfbc_pkg::CNT_W'(1)) begin
            state_next = brfbc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = brfbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ph] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && iss_mem) begin
      mem_q <= mem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      ph    <= '0;
      ovf   <= 1'b0;
      state <= brfbc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      ph    <= ph_next;
      ovf   <= ovf_next;
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        pv <= 1'b1;
      end else if (move) begin
        pv <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_status  <= iss_status;
      p_run_end <= iss_run_end;
      p_mem     <= iss_mem;
      p_fill    <= 8'(iss_fill);
    end
    if (move) begin
      out_data.status     <= p_status;
      out_data.rd_byte    <= p_mem ? mem_q : 8'd0;
      out_data.run_end    <= p_run_end;
      out_data.fill_count <= p_fill;
    end
  end

endmodule

// ===== sv/byte_ring_fifo_block_commit_top.sv =====
// Ring byte FIFO (256 entries, up to 255 bytes) with block-committed writes. Write requests
// need no result slot except the final byte of a block, which gives one status result. A
// read request of N bytes (1..64) enters the read state, which streams N results at one per
// cycle while the output does not stall; a rejected or zero-length read gives one result.
// Rate is set by the single write and single read port of the byte store and the one-entry
// result stage feeding the output register; a two-entry request queue separates input from
// execution. The store is not cleared at reset; only committed bytes are ever read.
`include "byte_ring_fifo_block_commit_top_defines.svh"

module byte_ring_fifo_block_commit_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  brfbc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output brfbc_pkg::out_t out_data
);

  logic            q_valid;
  logic            q_pop;
  brfbc_pkg::cmd_t q_cmd;

  brfbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  brfbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `BRFBC_IMPLIES(a_pop_has_req, q_pop, q_valid)
  `BRFBC_IMPLIES(a_fail_ends_run, out_valid && out_data.status, out_data.run_end)
  `BRFBC_IMPLIES(a_byte_only_ok, out_valid && (out_data.rd_byte != 8'd0), !out_data.status)

endmodule
